// ===== src/escaped_trailing_wildcard_matcher_assert.svh =====
// Assertion helpers shared by checker files.
`ifndef ESCAPED_TRAILING_WILDCARD_MATCHER_ASSERT_SVH
`define ESCAPED_TRAILING_WILDCARD_MATCHER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define ETWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ETWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/etwm_pkg.sv =====
package etwm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PosW        = $clog2(MAX_PATTERN + 1);
  localparam int AddrW       = $clog2(MAX_PATTERN);

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] STAR      = 8'h2A;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TOK_LIT  = 2'd0,
    TOK_STAR = 2'd1,
    TOK_BAD  = 2'd2
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    logic [PosW-1:0] tok_count;
    logic            star_end;
    logic            esc;
    logic            ok;
    logic            ovf;
  } pat_stat_t;

  typedef struct packed {
    op_e        op;
    logic       wr;
    tok_t       tok;
    logic [7:0] data;
    pat_stat_t  stat;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic valid;
  } res_t;

endpackage

// ===== src/escaped_trailing_wildcard_matcher.sv =====
// Escaped trailing-wildcard matcher.
// Input queue: drive operation_i/data_byte_i and raise push; a beat is taken on
// a rising edge with push high and full low. Operations: clear pattern, append
// pattern byte, subject byte, end of subject. Only end of subject yields a
// result beat.
// Result queue: while empty is low, matched_o and pattern_valid_o show the
// oldest result; raise pop to take it.
// Throughput: one beat per cycle while full is low, every operation. A front
// stage tokenizes the pattern (escapes, star placement, validity) as it is
// appended; a two-entry command queue feeds a back stage that walks a 64-entry
// token memory one token per subject byte, with the read for the next position
// issued in the same cycle the current byte is compared.
// Path: with both queues empty, an end-of-subject beat is registered in the
// command queue, then in the result queue, before the result ports show it.
// Reset: pattern empty, no overflow, comparison restarted, both queues empty.
// Receiver stall: up to two results wait in the back stage; then the command
// queue fills and full rises until pop frees a slot.
module escaped_trailing_wildcard_matcher import etwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       matched_o,
  output logic       pattern_valid_o
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic beat;
  logic cmd_valid;
  logic cmd_pop;

  assign beat = push && !full;

  etwm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .op_i   (operation_i),
    .data_i (data_byte_i),
    .cmd_o  (front_cmd)
  );

  etwm_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd)
  );

  etwm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (back_cmd),
    .cmd_pop_o       (cmd_pop),
    .res_empty_o     (empty),
    .res_pop_i       (pop),
    .matched_o       (matched_o),
    .pattern_valid_o (pattern_valid_o)
  );

endmodule

// ===== src/etwm_front.sv =====
module etwm_front import etwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  output cmd_t       cmd_o
);

  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] tok_q, tok_d;
  logic            esc_q, esc_d;
  logic            star_q, star_d;
  logic            bad_q, bad_d;
  logic            ovf_q, ovf_d;
  op_e             op;
  logic            esc_ok;

  assign op     = op_e'(op_i);
  assign esc_ok = (data_i == BACKSLASH) || (data_i == STAR);

  always_comb begin
    len_d  = len_q;
    tok_d  = tok_q;
    esc_d  = esc_q;
    star_d = star_q;
    bad_d  = bad_q;
    ovf_d  = ovf_q;

    cmd_o.op             = op;
    cmd_o.wr             = 1'b0;
    cmd_o.tok.kind       = TOK_LIT;
    cmd_o.tok.ch         = data_i;
    cmd_o.data           = data_i;
    cmd_o.stat.tok_count = tok_q;
    cmd_o.stat.star_end  = star_q;
    cmd_o.stat.esc       = esc_q;
    cmd_o.stat.ok        = !bad_q && !esc_q;
    cmd_o.stat.ovf       = ovf_q;

    case (op)
      OP_CLEAR: begin
        len_d  = '0;
        tok_d  = '0;
        esc_d  = 1'b0;
        star_d = 1'b0;
        bad_d  = 1'b0;
        ovf_d  = 1'b0;
      end
      OP_APPEND: begin
        if (len_q == PosW'(MAX_PATTERN)) begin
          ovf_d = 1'b1;
        end else begin
          len_d = len_q + PosW'(1);
          if (esc_q) begin
            cmd_o.wr       = 1'b1;
            cmd_o.tok.kind = esc_ok ? TOK_LIT : TOK_BAD;
            tok_d          = tok_q + PosW'(1);
            esc_d          = 1'b0;
            star_d         = 1'b0;
            if (!esc_ok) begin
              bad_d = 1'b1;
            end
          end else begin
            if (star_q) begin
              bad_d = 1'b1;
            end
            if (data_i == BACKSLASH) begin
              esc_d  = 1'b1;
              star_d = 1'b0;
            end else if (data_i == STAR) begin
              cmd_o.wr       = 1'b1;
              cmd_o.tok.kind = TOK_STAR;
              tok_d          = tok_q + PosW'(1);
              star_d         = 1'b1;
            end else begin
              cmd_o.wr = 1'b1;
              tok_d    = tok_q + PosW'(1);
              star_d   = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      tok_q  <= '0;
      esc_q  <= 1'b0;
      star_q <= 1'b0;
      bad_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (beat_i) begin
      len_q  <= len_d;
      tok_q  <= tok_d;
      esc_q  <= esc_d;
      star_q <= star_d;
      bad_q  <= bad_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== src/etwm_cmd_fifo.sv =====
module etwm_cmd_fifo import etwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/etwm_back.sv =====
module etwm_back import etwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_empty_o,
  input  logic res_pop_i,
  output logic matched_o,
  output logic pattern_valid_o
);

  typedef enum logic [1:0] {
    DEC_OPEN = 2'd0,
    DEC_STAR = 2'd1,
    DEC_FAIL = 2'd2
  } dec_e;

  tok_t            mem_q [MAX_PATTERN];
  tok_t            rd_q;
  logic [PosW-1:0] pos_q, pos_d;
  dec_e            dec_q, dec_d;

  res_t            res_q [2];
  res_t            res_new;
  logic            wptr_q;
  logic            rptr_q;
  logic [1:0]      cnt_q;

  logic             go;
  logic             res_push;
  logic             res_pop;
  logic             in_pat;
  logic             star_last;
  logic             wr_en;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign go        = cmd_valid_i && ((cmd_i.op != OP_END) || (cnt_q != 2'd2));
  assign cmd_pop_o = go;
  assign in_pat    = pos_q < cmd_i.stat.tok_count;
  assign star_last = cmd_i.stat.star_end &&
                     ((pos_q + PosW'(1)) == cmd_i.stat.tok_count);

  always_comb begin
    pos_d            = pos_q;
    dec_d            = dec_q;
    res_push         = 1'b0;
    res_new.matched  = 1'b0;
    res_new.valid    = 1'b0;
    if (go) begin
      case (cmd_i.op)
        OP_CLEAR, OP_APPEND: begin
          pos_d = '0;
          dec_d = DEC_OPEN;
        end
        OP_SUBJECT: begin
          if (dec_q == DEC_OPEN) begin
            if (!in_pat) begin
              dec_d = DEC_FAIL;
            end else begin
              case (rd_q.kind)
                TOK_LIT: begin
                  if (rd_q.ch == cmd_i.data) begin
                    pos_d = pos_q + PosW'(1);
                  end else begin
                    dec_d = DEC_FAIL;
                  end
                end
                TOK_STAR: dec_d = star_last ? DEC_STAR : DEC_FAIL;
                default:  dec_d = DEC_FAIL;
              endcase
            end
          end
        end
        default: begin
          case (dec_q)
            DEC_STAR: res_new.matched = 1'b1;
            DEC_OPEN: begin
              if (in_pat) begin
                res_new.matched = (rd_q.kind == TOK_STAR) && star_last;
              end else begin
                res_new.matched = !cmd_i.stat.esc;
              end
            end
            default: res_new.matched = 1'b0;
          endcase
          res_new.valid = cmd_i.stat.ok;
          if (cmd_i.stat.ovf) begin
            res_new.matched = 1'b0;
            res_new.valid   = 1'b0;
          end
          res_push = 1'b1;
          pos_d    = '0;
          dec_d    = DEC_OPEN;
        end
      endcase
    end
  end

  assign wr_en = go && (cmd_i.op == OP_APPEND) && cmd_i.wr;
  assign waddr = cmd_i.stat.tok_count[AddrW-1:0];
  assign raddr = pos_d[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= cmd_i.tok;
    end
    rd_q <= (wr_en && (waddr == raddr)) ? cmd_i.tok : mem_q[raddr];
  end

  assign res_pop         = res_pop_i && (cnt_q != 2'd0);
  assign res_empty_o     = (cnt_q == 2'd0);
  assign matched_o       = res_q[rptr_q].matched;
  assign pattern_valid_o = res_q[rptr_q].valid;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      dec_q  <= DEC_OPEN;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      pos_q <= pos_d;
      dec_q <= dec_d;
      if (res_push) begin
        wptr_q <= !wptr_q;
      end
      if (res_pop) begin
        rptr_q <= !rptr_q;
      end
      case ({res_push, res_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/etwm_checker.sv =====
`include "escaped_trailing_wildcard_matcher_assert.svh"

module etwm_checker import etwm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [1:0] operation_i,
  input logic [7:0] data_byte_i,
  input logic       empty,
  input logic       pop,
  input logic       matched_o,
  input logic       pattern_valid_o
);

  logic [3:0] pend_q;
  logic       end_beat;
  logic       res_beat;

  assign end_beat = push && !full && (op_e'(operation_i) == OP_END);
  assign res_beat = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'd0, end_beat} - {3'd0, res_beat};
    end
  end

  `ETWM_ASSERT(a_no_phantom_result, empty || (pend_q != 4'd0), "result without end beat")
  `ETWM_ASSERT(a_match_needs_valid, empty || !matched_o || pattern_valid_o, "match on bad pattern")
  `ETWM_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(matched_o) && $stable(pattern_valid_o), "result changed while stalled")

endmodule

bind escaped_trailing_wildcard_matcher etwm_checker u_etwm_checker (.*);
